// ----- sv/bmp_pkg.sv -----
// shared types and constants for the 3x3 box mean with peak block
// used by bmp_front, bmp_fifo, bmp_back and box_mean_3x3_with_peak
package bmp_pkg;

  // field widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned PosW     = 10;
  localparam int unsigned ColSumW  = 18;  // three samples
  localparam int unsigned SumW     = 20;  // nine samples

  // grid size defaults
  localparam int unsigned DefGridCols = 5;
  localparam int unsigned DefGridRows = 5;

  // divide by nine: q = (a * RecipM) >> RecipShift, exact for a < 2^19
  localparam int unsigned RecipW     = 19;
  localparam int unsigned RecipShift = 22;
  localparam logic [RecipW-1:0] RecipM = 19'd466034;
  localparam int unsigned ProdW      = SumW + RecipW;
  localparam int unsigned QuotW      = SampleW + 1;

  // peak reset value, most negative sample
  localparam logic signed [SampleW-1:0] PeakInit = 16'sh8000;

  // one full window handed from front to back
  typedef struct packed {
    logic signed [SumW-1:0] sum;
    logic [PosW-1:0]        row;
    logic [PosW-1:0]        col;
    logic                   last;
  } win_t;

endpackage

// ----- sv/bmp_front.sv -----
// front part: line stores, column sums, position counters and window classification
// depends on bmp_pkg
module bmp_front #(
  parameter int unsigned GRID_COLS = bmp_pkg::DefGridCols,
  parameter int unsigned GRID_ROWS = bmp_pkg::DefGridRows
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [bmp_pkg::SampleW-1:0]  sample_i,
  output logic                                win_valid_o,
  input  logic                                win_ready_i,
  output bmp_pkg::win_t                       win_o
);

  localparam int unsigned AddrW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int unsigned SW    = bmp_pkg::SampleW;
  localparam int unsigned CW    = bmp_pkg::ColSumW;
  localparam int unsigned PW    = bmp_pkg::PosW;

  logic [2*SW-1:0] mem_q [GRID_COLS];
  logic [2*SW-1:0] rd_q;

  logic [PW-1:0] col_q, col_d, row_q, row_d;
  logic          s1_valid_q, s1_valid_d;
  logic [PW-1:0] s1_row_q, s1_col_q;
  logic          s1_last_q;
  logic signed [CW-1:0] cs0_q, cs1_q, cs2_q, cs_new;

  logic accept, push, last, has_result;
  logic signed [SW-1:0] top, mid;

  // handshake
  assign push       = s1_valid_q && win_ready_i;
  assign in_ready_o = !s1_valid_q || win_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // classify the incoming sample
  assign last       = (row_q == PW'(GRID_ROWS - 1)) && (col_q == PW'(GRID_COLS - 1));
  assign has_result = (row_q >= PW'(2)) && (col_q >= PW'(2));

  // position counters, next values
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_q >= PW'(GRID_COLS - 1)) begin
        col_d = '0;
        row_d = row_q + PW'(1);
      end else begin
        col_d = col_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line stores, one entry holds upper and middle; next column is read ahead
  assign top = rd_q[2*SW-1:SW];
  assign mid = rd_q[SW-1:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[col_q[AddrW-1:0]] <= {mid, sample_i};
      rd_q                    <= mem_q[col_d[AddrW-1:0]];
    end
  end

  // column sums of the sliding window
  assign cs_new = CW'(top) + CW'(mid) + CW'(sample_i);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cs0_q <= cs1_q;
      cs1_q <= cs2_q;
      cs2_q <= cs_new;
    end
  end

  // window stage valid
  always_comb begin
    if (accept) begin
      s1_valid_d = has_result;
    end else begin
      s1_valid_d = s1_valid_q && !push;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_row_q  <= row_q - PW'(2);
      s1_col_q  <= col_q - PW'(2);
      s1_last_q <= last;
    end
  end

  // window sum goes out with its position
  assign win_valid_o = s1_valid_q;
  assign win_o.sum   = bmp_pkg::SumW'(cs0_q) + bmp_pkg::SumW'(cs1_q) + bmp_pkg::SumW'(cs2_q);
  assign win_o.row   = s1_row_q;
  assign win_o.col   = s1_col_q;
  assign win_o.last  = s1_last_q;

endmodule

// ----- sv/bmp_fifo.sv -----
// two-entry queue between front and back parts
// depends on bmp_pkg
module bmp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  bmp_pkg::win_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output bmp_pkg::win_t pop_data_o
);

  bmp_pkg::win_t entry_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;
  logic          push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ----- sv/bmp_back.sv -----
// back part: divide by nine with rounding, running peak and output register
// depends on bmp_pkg
module bmp_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               win_valid_i,
  output logic                               win_ready_o,
  input  bmp_pkg::win_t                      win_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [bmp_pkg::SampleW-1:0] window_mean_o,
  output logic signed [bmp_pkg::SampleW-1:0] peak_mean_o,
  output logic [bmp_pkg::PosW-1:0]           window_row_o,
  output logic [bmp_pkg::PosW-1:0]           window_col_o,
  output logic                               last_window_o
);

  localparam int unsigned SW = bmp_pkg::SampleW;
  localparam int unsigned PW = bmp_pkg::PosW;
  localparam int unsigned QW = bmp_pkg::QuotW;

  logic b1_valid_q, out_valid_q;
  logic b1_adv, b2_adv, b2_ready;
  logic [bmp_pkg::ProdW-1:0] prod_q;
  logic          b1_neg_q, b1_last_q;
  logic [PW-1:0] b1_row_q, b1_col_q;
  logic [bmp_pkg::SumW-1:0] mag, a;
  logic [QW-1:0] quot, mean_ext;
  logic signed [SW-1:0] mean, new_peak, peak_q;

  // stall control, a stage advances when it is empty or the stage after it is ready
  assign b2_ready    = !out_valid_q || out_ready_i;
  assign win_ready_o = !b1_valid_q || b2_ready;
  assign b1_adv      = win_valid_i && win_ready_o;
  assign b2_adv      = b1_valid_q && b2_ready;

  // magnitude plus half the divisor, times reciprocal
  assign mag = win_i.sum[bmp_pkg::SumW-1] ? bmp_pkg::SumW'(-win_i.sum)
                                          : bmp_pkg::SumW'(win_i.sum);
  assign a   = mag + bmp_pkg::SumW'(4);

  always_ff @(posedge clk_i) begin
    if (b1_adv) begin
      prod_q    <= bmp_pkg::ProdW'(a) * bmp_pkg::ProdW'(bmp_pkg::RecipM);
      b1_neg_q  <= win_i.sum[bmp_pkg::SumW-1];
      b1_row_q  <= win_i.row;
      b1_col_q  <= win_i.col;
      b1_last_q <= win_i.last;
    end
  end

  // signed mean and peak update
  assign quot     = prod_q[bmp_pkg::RecipShift +: QW];
  assign mean_ext = b1_neg_q ? (QW'(0) - quot) : quot;
  assign mean     = mean_ext[SW-1:0];
  assign new_peak = (mean > peak_q) ? mean : peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      peak_q      <= bmp_pkg::PeakInit;
    end else begin
      if (win_ready_o) b1_valid_q <= win_valid_i;
      if (b2_ready)    out_valid_q <= b1_valid_q;
      if (b2_adv)      peak_q <= b1_last_q ? bmp_pkg::PeakInit : new_peak;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (b2_adv) begin
      window_mean_o <= mean;
      peak_mean_o   <= new_peak;
      window_row_o  <= b1_row_q;
      window_col_o  <= b1_col_q;
      last_window_o <= b1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/box_mean_3x3_with_peak.sv -----
// top level of the streaming 3x3 box mean with running peak
// depends on bmp_pkg, bmp_front, bmp_fifo and bmp_back
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------------
//   input    | in_valid_i / in_ready_o | sample_i
//   output   | out_valid_o/out_ready_i | window_mean_o peak_mean_o window_row_o
//            |                         | window_col_o last_window_o
//
// one sample is taken each cycle while in_ready_o is high; samples in the first
// two rows or columns give no result. a result leaves through the window stage,
// queue, multiply stage and output register.
// reset clears counters, valid flags and the peak; line stores hold garbage until
// written in the current frame. output stalls back up through the two-entry queue
// to the input only once the queue and the back stages are full.
module box_mean_3x3_with_peak #(
  parameter int unsigned GRID_COLS = bmp_pkg::DefGridCols,
  parameter int unsigned GRID_ROWS = bmp_pkg::DefGridRows
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [bmp_pkg::SampleW-1:0] sample_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [bmp_pkg::SampleW-1:0] window_mean_o,
  output logic signed [bmp_pkg::SampleW-1:0] peak_mean_o,
  output logic [bmp_pkg::PosW-1:0]           window_row_o,
  output logic [bmp_pkg::PosW-1:0]           window_col_o,
  output logic                               last_window_o
);

  localparam int unsigned PW = bmp_pkg::PosW;

  logic          f_valid, f_ready, q_valid, q_ready;
  bmp_pkg::win_t f_win, q_win;

  // front: accept and classify samples
  bmp_front #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .win_valid_o (f_valid),
    .win_ready_i (f_ready),
    .win_o       (f_win)
  );

  // queue between the parts
  bmp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_win),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_win)
  );

  // back: mean, peak, output
  bmp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .win_valid_i   (q_valid),
    .win_ready_o   (q_ready),
    .win_i         (q_win),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .window_mean_o (window_mean_o),
    .peak_mean_o   (peak_mean_o),
    .window_row_o  (window_row_o),
    .window_col_o  (window_col_o),
    .last_window_o (last_window_o)
  );

  // peak never falls below the mean it was updated with
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (peak_mean_o >= window_mean_o))
    else $error("peak below window mean");

  // last window sits at the bottom right corner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_window_o) |->
      (window_row_o == PW'(GRID_ROWS - 3)) && (window_col_o == PW'(GRID_COLS - 3)))
    else $error("last window flagged away from corner");

  // positions stay inside the valid region
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (window_row_o <= PW'(GRID_ROWS - 3)) && (window_col_o <= PW'(GRID_COLS - 3)))
    else $error("window position out of range");

endmodule
